// File: sv/wmpct_pkg.sv
// shared constants for the wheel mouse packet cursor tracker
package wmpct_pkg;

  // stream widths
  localparam int unsigned IN_TDATA_BITS  = 8;
  localparam int unsigned OUT_TDATA_BITS = 48;

  // result field widths as they appear on the output word
  localparam int unsigned OUT_COORD_BITS = 12;
  localparam int unsigned OUT_WHEEL_BITS = 16;

  // configuration port
  localparam int unsigned CFG_INDEX_BITS = 1;
  localparam int unsigned CFG_DATA_BITS  = 13;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 1'd1;
  localparam logic [CFG_DATA_BITS-1:0]  SCREEN_WIDTH_RST  = 13'd640;
  localparam logic [CFG_DATA_BITS-1:0]  SCREEN_HEIGHT_RST = 13'd480;

  // motion delta width after sign extension, wide enough for a negated 9-bit value
  localparam int unsigned DELTA_BITS = 10;

  // position of the byte that completes a packet
  localparam logic [1:0] BYTE_LAST = 2'd3;

  // bit positions inside the report bytes
  localparam int unsigned B0_BUTTON1 = 0;
  localparam int unsigned B0_BUTTON2 = 1;
  localparam int unsigned B0_BUTTON3 = 2;
  localparam int unsigned B0_SIGN_X  = 4;
  localparam int unsigned B0_SIGN_Y  = 5;
  localparam int unsigned B3_WHEEL_SIGN = 3;
  localparam int unsigned B3_BUTTON4 = 4;
  localparam int unsigned B3_BUTTON5 = 5;

endpackage

// File: sv/wmpct_clamp.sv
// adds a signed motion delta to one cursor coordinate and clamps it to the screen
module wmpct_clamp
  import wmpct_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic [COORD_BITS-1:0]    pos,
  input  logic [DELTA_BITS-1:0]    delta,
  input  logic [CFG_DATA_BITS-1:0] size,
  output logic [COORD_BITS-1:0]    pos_next
);

  localparam int unsigned SUM_BITS =
    ((COORD_BITS > CFG_DATA_BITS) ? COORD_BITS : CFG_DATA_BITS) + 2;

  logic [SUM_BITS-1:0] sum;
  logic [SUM_BITS-1:0] lim_raw;
  logic [SUM_BITS-1:0] coord_max;
  logic [SUM_BITS-1:0] lim;
  logic [SUM_BITS-1:0] result;

  // sum is two's complement, msb set means below zero
  assign sum = {{(SUM_BITS-COORD_BITS){1'b0}}, pos}
             + {{(SUM_BITS-DELTA_BITS){delta[DELTA_BITS-1]}}, delta};

  assign lim_raw = (size == '0) ? '0
                 : {{(SUM_BITS-CFG_DATA_BITS){1'b0}}, size - {{(CFG_DATA_BITS-1){1'b0}}, 1'b1}};
  assign coord_max = {{(SUM_BITS-COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}};
  assign lim = (lim_raw > coord_max) ? coord_max : lim_raw;

  always_comb begin
    if (sum[SUM_BITS-1]) begin
      result = '0;
    end else if (sum > lim) begin
      result = lim;
    end else begin
      result = sum;
    end
  end

  assign pos_next = result[COORD_BITS-1:0];

endmodule

// File: sv/wheel_mouse_packet_cursor_tracker.sv
// top level of the wheel mouse packet decoder and cursor tracker
//
// input stream: one report byte per word on s_tdata, four words make a packet;
// bytes are grouped strictly by count since reset, there is no sync check
// output stream: one word per packet carrying the clamped cursor, the
// accumulated wheel position and the five button flags
// configuration: cfg_we writes cfg_data into screen width (index 0) or
// screen height (index 1); write only while the block is idle
// latency: a byte accepted at one edge is decoded at the next edge, so m_tvalid
// rises one cycle after the edge that takes a packet's fourth byte and the
// word can be taken at the second edge after it
// throughput: one byte per cycle, set by the input register feeding the
// single decode and clamp stage that writes the result register
// stall: while the result register is full and m_tready is low, the fourth
// byte of the next packet waits in the input register and s_tready drops;
// the first three bytes of a packet still pass since they give no result
// reset: clears the byte counter, cursor, wheel position and both valid
// flags, and loads the screen size with 640 by 480
module wheel_mouse_packet_cursor_tracker
  import wmpct_pkg::*;
#(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned WHEEL_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  // input stream
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [IN_TDATA_BITS-1:0]  s_tdata,   // [7:0] packet_byte
  // output stream
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // [11:0] cursor_x, [23:12] cursor_y, [39:24] wheel_pos, [40] button1,
  // [41] button2, [42] button3, [43] button4, [44] button5, [47:45] zero
  output logic [OUT_TDATA_BITS-1:0] m_tdata,
  // configuration write port
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  // configuration registers
  logic [CFG_DATA_BITS-1:0] screen_width;
  logic [CFG_DATA_BITS-1:0] screen_height;

  // input register
  logic                     in_valid;
  logic [7:0]               in_byte;

  // packet state
  logic [1:0]               byte_position;
  logic [2:0][7:0]          held_bytes;
  logic [COORD_BITS-1:0]    pos_x;
  logic [COORD_BITS-1:0]    pos_y;
  logic [WHEEL_BITS-1:0]    wheel_acc;

  // result register
  logic                      out_valid;
  logic [OUT_TDATA_BITS-1:0] out_data;

  // decode
  logic                      out_free;
  logic                      last_byte;
  logic                      proceed;
  logic                      finish;
  logic [DELTA_BITS-1:0]     dx;
  logic [DELTA_BITS-1:0]     dy;
  logic [DELTA_BITS-1:0]     neg_dy;
  logic [WHEEL_BITS-1:0]     dz;
  logic [COORD_BITS-1:0]     pos_x_next;
  logic [COORD_BITS-1:0]     pos_y_next;
  logic [WHEEL_BITS-1:0]     wheel_acc_next;
  logic [COORD_BITS+OUT_COORD_BITS-1:0] x_wide;
  logic [COORD_BITS+OUT_COORD_BITS-1:0] y_wide;
  logic [WHEEL_BITS+OUT_WHEEL_BITS-1:0] wheel_wide;
  logic [OUT_TDATA_BITS-1:0] out_data_next;

  // handshake: the input register moves on unless it holds a packet's last
  // byte and the result register cannot take a new word
  assign out_free  = !out_valid || m_tready;
  assign last_byte = (byte_position == BYTE_LAST);
  assign proceed   = in_valid && (!last_byte || out_free);
  assign finish    = proceed && last_byte;
  assign s_tready  = !in_valid || proceed;
  assign m_tvalid  = out_valid;
  assign m_tdata   = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= SCREEN_WIDTH_RST;
      screen_height <= SCREEN_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  // motion deltas: 9-bit signed values with their sign bits in byte 0
  assign dx     = {{(DELTA_BITS-8){held_bytes[0][B0_SIGN_X]}}, held_bytes[1]};
  assign dy     = {{(DELTA_BITS-8){held_bytes[0][B0_SIGN_Y]}}, held_bytes[2]};
  assign neg_dy = '0 - dy;  // screen y grows downward
  assign dz     = {{(WHEEL_BITS-4){in_byte[B3_WHEEL_SIGN]}}, in_byte[3:0]};

  wmpct_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_x (
    .pos      (pos_x),
    .delta    (dx),
    .size     (screen_width),
    .pos_next (pos_x_next)
  );

  wmpct_clamp #(.COORD_BITS(COORD_BITS)) u_clamp_y (
    .pos      (pos_y),
    .delta    (neg_dy),
    .size     (screen_height),
    .pos_next (pos_y_next)
  );

  assign wheel_acc_next = wheel_acc + dz;

  // fit internal widths onto the fixed output fields
  assign x_wide     = {{OUT_COORD_BITS{1'b0}}, pos_x_next};
  assign y_wide     = {{OUT_COORD_BITS{1'b0}}, pos_y_next};
  assign wheel_wide = {{OUT_WHEEL_BITS{1'b0}}, wheel_acc_next};

  assign out_data_next = {
    3'b000,
    in_byte[B3_BUTTON5],
    in_byte[B3_BUTTON4],
    held_bytes[0][B0_BUTTON3],
    held_bytes[0][B0_BUTTON2],
    held_bytes[0][B0_BUTTON1],
    wheel_wide[OUT_WHEEL_BITS-1:0],
    y_wide[OUT_COORD_BITS-1:0],
    x_wide[OUT_COORD_BITS-1:0]
  };

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      pos_x         <= '0;
      pos_y         <= '0;
      wheel_acc     <= '0;
    end else if (proceed) begin
      byte_position <= byte_position + 2'd1;  // wraps to zero after the last byte
      if (last_byte) begin
        pos_x     <= pos_x_next;
        pos_y     <= pos_y_next;
        wheel_acc <= wheel_acc_next;
      end
    end
  end

  // held bytes need no reset: each one is written before it is read
  always_ff @(posedge clk) begin
    if (proceed && !last_byte) begin
      held_bytes[byte_position] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= finish;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data <= out_data_next;
    end
  end

endmodule

// File: sv/wmpct_chk.sv
// port-level checks for the wheel mouse packet cursor tracker, bound to the top level
module wmpct_chk
  import wmpct_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic [IN_TDATA_BITS-1:0]  s_tdata,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [OUT_TDATA_BITS-1:0] m_tdata,
  input logic                      cfg_we,
  input logic [CFG_INDEX_BITS-1:0] cfg_index,
  input logic [CFG_DATA_BITS-1:0]  cfg_data
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word present after reset");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // a new result follows a byte accepted into the input register and decoded into the result register
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result word without a completing byte");

  // pad bits of the result word stay zero
  a_out_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_TDATA_BITS-1:45] == '0)
    else $error("result pad bits not zero");

endmodule

bind wheel_mouse_packet_cursor_tracker wmpct_chk u_wmpct_chk (.*);
